// ----- src/pmrb_pkg.sv -----
`timescale 1ns / 1ps
package pmrb_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_OX0 = 2'd0,
    REG_OY0 = 2'd1,
    REG_OX1 = 2'd2,
    REG_OY1 = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               source;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [8:0]         bin_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] bin_range;
    logic        bin_empty;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_SQRT,
    ST_BIN,
    ST_RD,
    ST_WR,
    ST_CLR
  } state_t;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS = 17;
  localparam int CFG_IDX_W = 3;

  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0:  atan_turn = 30'd536870912;
      5'd1:  atan_turn = 30'd316933406;
      5'd2:  atan_turn = 30'd167458907;
      5'd3:  atan_turn = 30'd85004756;
      5'd4:  atan_turn = 30'd42667331;
      5'd5:  atan_turn = 30'd21354465;
      5'd6:  atan_turn = 30'd10680862;
      5'd7:  atan_turn = 30'd5340245;
      5'd8:  atan_turn = 30'd2670163;
      5'd9:  atan_turn = 30'd1335087;
      5'd10: atan_turn = 30'd667544;
      5'd11: atan_turn = 30'd333772;
      5'd12: atan_turn = 30'd166886;
      5'd13: atan_turn = 30'd83443;
      5'd14: atan_turn = 30'd41722;
      5'd15: atan_turn = 30'd20861;
      5'd16: atan_turn = 30'd10430;
      5'd17: atan_turn = 30'd5215;
      5'd18: atan_turn = 30'd2608;
      5'd19: atan_turn = 30'd1304;
      5'd20: atan_turn = 30'd652;
      5'd21: atan_turn = 30'd326;
      5'd22: atan_turn = 30'd163;
      5'd23: atan_turn = 30'd81;
      default: atan_turn = 30'd0;
    endcase
  endfunction

endpackage

// ----- src/pmrb_ram.sv -----
`timescale 1ns / 1ps
module pmrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 360
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/pmrb_polar.sv -----
`timescale 1ns / 1ps
module pmrb_polar
  import pmrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [16:0] x_in,
  input  logic signed [16:0] y_in,
  output logic               done,
  output logic [32:0]        angle_sh,
  output logic [15:0]        range
);

  // cordic datapath: 17 bit input scaled by 2^14 plus growth
  logic signed [34:0] cx, cy, cx_next, cy_next;
  logic signed [33:0] cz, cz_next;
  logic [4:0]         step;
  logic               c_run, axis;
  logic [32:0]        axis_angle;
  // sqrt datapath
  logic [33:0]        rem, rem_next;
  logic [16:0]        root, root_next;
  logic [4:0]         sstep;
  logic               s_run;
  logic signed [34:0] sx, sy;
  logic signed [33:0] a_full;
  logic signed [33:0] xsq, ysq;

  assign sx = cx >>> step;
  assign sy = cy >>> step;

  // one vectoring micro-rotation
  always_comb begin
    if (cy > 0) begin
      cx_next = cx + sy;
      cy_next = cy - sx;
      cz_next = cz + $signed({4'd0, atan_turn(step)});
    end else begin
      cx_next = cx - sy;
      cy_next = cy + sx;
      cz_next = cz - $signed({4'd0, atan_turn(step)});
    end
  end

  // squared magnitude registered, then one root bit per cycle
  // trial value for bit k is root * 2^(k+1) + 4^k
  always_comb begin
    logic [4:0]  kk;
    logic [35:0] cand;
    logic [35:0] cur;
    kk = 5'd16 - sstep;
    cur = {2'b00, rem};
    cand = (36'(root) << (kk + 5'd1)) + (36'd1 << {kk, 1'b0});
    if (cur >= cand) begin
      rem_next = 34'(cur - cand);
      root_next = root | (17'd1 << kk);
    end else begin
      rem_next = rem;
      root_next = root;
    end
  end

  assign a_full = cz + 34'sd2147483648;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_run <= 1'b0;
      s_run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        c_run <= 1'b1;
        s_run <= 1'b0;
        step <= '0;
        xsq <= 34'(x_in * x_in);
        ysq <= 34'(y_in * y_in);
        axis <= (y_in == 0) || (x_in == 0);
        if (y_in == 0) begin
          axis_angle <= (x_in < 0) ? 33'h100000000 : 33'h080000000;
        end else begin
          axis_angle <= (y_in > 0) ? 33'h0C0000000 : 33'h040000000;
        end
        if (x_in < 0 && y_in > 0) begin
          cx <= 35'(y_in) <<< 14;
          cy <= -(35'(x_in) <<< 14);
          cz <= 34'sd1073741824;
        end else if (x_in < 0) begin
          cx <= -(35'(y_in) <<< 14);
          cy <= 35'(x_in) <<< 14;
          cz <= -34'sd1073741824;
        end else begin
          cx <= 35'(x_in) <<< 14;
          cy <= 35'(y_in) <<< 14;
          cz <= '0;
        end
      end else if (c_run) begin
        cx <= cx_next;
        cy <= cy_next;
        cz <= cz_next;
        step <= step + 5'd1;
        if (step == 5'(CORDIC_STEPS - 1)) begin
          c_run <= 1'b0;
          s_run <= 1'b1;
          sstep <= '0;
          rem <= 34'(xsq + ysq);
          root <= '0;
        end
      end else if (s_run) begin
        rem <= rem_next;
        root <= root_next;
        sstep <= sstep + 5'd1;
        if (sstep == 5'(SQRT_STEPS - 1)) begin
          s_run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // outputs valid with done
  always_comb begin
    if (axis) begin
      angle_sh = axis_angle;
    end else if (a_full < 0) begin
      angle_sh = '0;
    end else if (a_full > 34'sh0FFFFFFFF) begin
      angle_sh = 33'h0FFFFFFFF;
    end else begin
      angle_sh = 33'(a_full);
    end
    range = (root > 17'd65535) ? 16'hFFFF : root[15:0];
  end

endmodule

// ----- src/polar_min_range_binner_unit.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// cmd       in         start / busy        in_item (in_item_t)
// result    out        result_strobe       result (out_item_t), one cycle
// cfg       in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// an insert keeps busy high after its transfer through 24 cordic steps
// and 17 root steps in the polar unit, the done pulse, the bin lookup read,
// then the compare and write back, skipped when the bin is out of range.
// a read is busy in ST_RD and its result shows in the cycle after that.
// a clear sweeps all bins; reset starts the same sweep.
// the receiver cannot stall; busy holds off new commands while one is in work.
module polar_min_range_binner_unit
  import pmrb_pkg::*;
#(
  parameter int NUM_BINS = 360
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 result_strobe,
  output out_item_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [13:0]          cfg_data
);

  localparam int AW = $clog2(NUM_BINS);

  state_t state, state_next;
  logic signed [13:0] off_x0, off_y0, off_x1, off_y1;
  logic signed [16:0] sx, sy;
  logic polar_done;
  logic [32:0] ang;
  logic [15:0] rng;
  logic [15:0] rng_q;
  logic [63:0] prod;
  logic [AW-1:0] bin, waddr, raddr;
  logic bin_ok;
  logic [16:0] rdata;
  logic [16:0] wdata;
  logic we;
  logic [AW:0] clr_cnt;
  logic rd_hit;

  assign cfg_ready = 1'b1;
  assign busy = (state != ST_IDLE);

  // offset registers
  always_ff @(posedge clk) begin
    if (rst) begin
      off_x0 <= -14'sd230;
      off_y0 <= '0;
      off_x1 <= '0;
      off_y1 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        3'(REG_OX0): off_x0 <= cfg_data;
        3'(REG_OY0): off_y0 <= cfg_data;
        3'(REG_OX1): off_x1 <= cfg_data;
        3'(REG_OY1): off_y1 <= cfg_data;
        default: ;
      endcase
    end
  end

  // shift and saturate to 17 bits
  function automatic logic signed [16:0] sat17(input logic signed [17:0] v);
    if (v > 18'sd65535) sat17 = 17'sd65535;
    else if (v < -18'sd65536) sat17 = -17'sd65536;
    else sat17 = v[16:0];
  endfunction

  assign sx = sat17(18'(in_item.point_x) + 18'(in_item.source ? off_x1 : off_x0));
  assign sy = sat17(18'(in_item.point_y) + 18'(in_item.source ? off_y1 : off_y0));

  pmrb_polar u_polar (
    .clk      (clk),
    .rst      (rst),
    .go       (start && !busy && in_item.action == ACT_INSERT),
    .x_in     (sx),
    .y_in     (sy),
    .done     (polar_done),
    .angle_sh (ang),
    .range    (rng)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (start) begin
          case (in_item.action)
            ACT_INSERT: state_next = ST_CORDIC;
            ACT_READ:   state_next = ST_RD;
            ACT_CLEAR:  state_next = ST_CLR;
            default:    state_next = ST_IDLE;
          endcase
        end
      ST_CORDIC: if (polar_done) state_next = ST_BIN;
      ST_SQRT:   state_next = ST_BIN;
      ST_BIN:    state_next = bin_ok ? ST_WR : ST_IDLE;
      ST_WR:     state_next = ST_IDLE;
      ST_RD:     state_next = ST_IDLE;
      ST_CLR:    if (clr_cnt == (AW+1)'(NUM_BINS - 1)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // bin ram holds {filled, nearest range}; clear sweep or conditional update
  assign raddr = (state == ST_IDLE) ? AW'(in_item.bin_index) : bin;
  assign we = (state == ST_CLR) ||
              ((state == ST_WR) && (!rdata[16] || rng_q < rdata[15:0]));
  assign waddr = (state == ST_CLR) ? AW'(clr_cnt) : bin;
  assign wdata = (state == ST_CLR) ? 17'd0 : {1'b1, rng_q};

  pmrb_ram #(.WIDTH(17), .DEPTH(NUM_BINS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign prod = 64'(ang) * 64'(NUM_BINS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      clr_cnt <= '0;
      result_strobe <= 1'b0;
    end else begin
      state <= state_next;
      result_strobe <= (state == ST_RD);
      if (state == ST_IDLE && start) begin
        rd_hit <= (32'(in_item.bin_index) < 32'(NUM_BINS));
        clr_cnt <= '0;
      end
      if (polar_done) begin
        bin <= AW'(prod[63:32]);
        bin_ok <= (prod[63:32] < 32'(NUM_BINS));
        rng_q <= rng;
      end
      if (state == ST_CLR) clr_cnt <= clr_cnt + (AW+1)'(1);
      if (state == ST_RD) begin
        if (rd_hit && rdata[16]) begin
          result.bin_range <= rdata[15:0];
          result.bin_empty <= 1'b0;
        end else begin
          result.bin_range <= '0;
          result.bin_empty <= 1'b1;
        end
      end
    end
  end

endmodule
